// ===== rtl/core/gbbt_pkg.sv =====
package gbbt_pkg;

  // field widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned RAD_W   = 31;

  // table size default and the cap on results of one query
  localparam int unsigned MAX_GRIDS_DEF = 32;
  localparam int unsigned MAX_RESULTS   = 32;
  localparam int unsigned RES_CNT_W     = $clog2(MAX_RESULTS);

  // start bounds of a new box, 999999.0 in Q23.8
  localparam logic signed [COORD_W-1:0] START_BOUND     = 32'sd255999744;
  localparam logic signed [COORD_W-1:0] START_BOUND_NEG = -32'sd255999744;

  // function codes
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    logic [ID_W-1:0]           key;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] max_z;
  } entry_t;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_add;  // compare keys against the incoming id
    logic cmp_qry;  // test the query point against the grown box
    logic ins;      // insert a new entry, cells past the slot shift right
    logic upd;      // widen the box of the cell whose key matched
  } cell_ctrl_t;

endpackage

// ===== rtl/core/gbbt_cell.sv =====
module gbbt_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  gbbt_pkg::cell_ctrl_t                  ctrl_i,
  input  logic                                  valid_i,
  input  logic [gbbt_pkg::ID_W-1:0]             cmp_id_i,
  input  gbbt_pkg::point_t                      pt_i,
  input  logic [gbbt_pkg::RAD_W-1:0]            radius_i,
  input  logic [gbbt_pkg::ID_W-1:0]             new_id_i,
  input  gbbt_pkg::point_t                      vtx_i,
  input  gbbt_pkg::entry_t                      left_entry_i,
  input  logic                                  left_lt_i,
  input  logic                                  pick_i,
  output gbbt_pkg::entry_t                      entry_o,
  output logic                                  lt_o,
  output logic                                  eq_o,
  output logic                                  match_o
);

  gbbt_pkg::entry_t entry_q, entry_d;
  logic lt_q, lt_d, eq_q, eq_d, match_q, match_d;

  // inclusive test of p against [lo - r, hi + r], formed wide so nothing wraps
  function automatic logic in_range(input logic signed [gbbt_pkg::COORD_W-1:0] p,
                                    input logic signed [gbbt_pkg::COORD_W-1:0] lo,
                                    input logic signed [gbbt_pkg::COORD_W-1:0] hi,
                                    input logic [gbbt_pkg::RAD_W-1:0] r);
    logic signed [gbbt_pkg::COORD_W+1:0] p_w;
    logic signed [gbbt_pkg::COORD_W+1:0] lo_w;
    logic signed [gbbt_pkg::COORD_W+1:0] hi_w;
    logic signed [gbbt_pkg::COORD_W+1:0] r_w;
    p_w  = {{2{p[gbbt_pkg::COORD_W-1]}}, p};
    r_w  = $signed({3'b000, r});
    lo_w = {{2{lo[gbbt_pkg::COORD_W-1]}}, lo} - r_w;
    hi_w = {{2{hi[gbbt_pkg::COORD_W-1]}}, hi} + r_w;
    return (p_w >= lo_w) && (p_w <= hi_w);
  endfunction

  function automatic logic signed [gbbt_pkg::COORD_W-1:0] smin(
      input logic signed [gbbt_pkg::COORD_W-1:0] a,
      input logic signed [gbbt_pkg::COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [gbbt_pkg::COORD_W-1:0] smax(
      input logic signed [gbbt_pkg::COORD_W-1:0] a,
      input logic signed [gbbt_pkg::COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // entry update: widen in place, insert here, or take the left neighbor
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.upd && eq_q) begin
      entry_d.min_x = smin(entry_q.min_x, vtx_i.x);
      entry_d.max_x = smax(entry_q.max_x, vtx_i.x);
      entry_d.min_y = smin(entry_q.min_y, vtx_i.y);
      entry_d.max_y = smax(entry_q.max_y, vtx_i.y);
      entry_d.min_z = smin(entry_q.min_z, vtx_i.z);
      entry_d.max_z = smax(entry_q.max_z, vtx_i.z);
    end else if (ctrl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        entry_d.key   = new_id_i;
        entry_d.min_x = smin(gbbt_pkg::START_BOUND, vtx_i.x);
        entry_d.max_x = smax(gbbt_pkg::START_BOUND_NEG, vtx_i.x);
        entry_d.min_y = smin(gbbt_pkg::START_BOUND, vtx_i.y);
        entry_d.max_y = smax(gbbt_pkg::START_BOUND_NEG, vtx_i.y);
        entry_d.min_z = smin(gbbt_pkg::START_BOUND, vtx_i.z);
        entry_d.max_z = smax(gbbt_pkg::START_BOUND_NEG, vtx_i.z);
      end else begin
        entry_d = left_entry_i;
      end
    end
  end

  // per-cell flags from the compare cycle
  always_comb begin
    lt_d    = lt_q;
    eq_d    = eq_q;
    match_d = match_q;
    if (ctrl_i.cmp_add) begin
      lt_d = valid_i && (entry_q.key < cmp_id_i);
      eq_d = valid_i && (entry_q.key == cmp_id_i);
    end
    if (ctrl_i.cmp_qry) begin
      match_d = valid_i &&
                in_range(pt_i.x, entry_q.min_x, entry_q.max_x, radius_i) &&
                in_range(pt_i.y, entry_q.min_y, entry_q.max_y, radius_i) &&
                in_range(pt_i.z, entry_q.min_z, entry_q.max_z, radius_i);
    end else if (pick_i) begin
      match_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
      match_q <= 1'b0;
    end else begin
      lt_q    <= lt_d;
      eq_q    <= eq_d;
      match_q <= match_d;
    end
  end

  // box payload, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;
  assign match_o = match_q;

endmodule

// ===== rtl/core/grid_bounding_box_table.sv =====
// Table of axis-aligned bounding boxes, one per grid id, kept in ascending id
// order in a chain of cells; each cell holds one entry and its compare flags.
// Input channel (in_valid_i / in_stall_o) takes one beat per item: func_i
// selects add vertex, query point or clear. Output channel (out_valid_o /
// out_stall_i) returns result beats; last_o marks the final beat of an item.
// Add: a compare of all cells against the id, then, once the output register
// is free, a step that widens the matching box or inserts a new entry (cells
// past the slot shift right). A new item is not taken until the result beat
// is registered. Full table on a new id returns status_o = 1 and drops the
// vertex.
// Query: a compare across all cells, then one match beat per cycle while the
// receiver does not stall, in ascending id order (at most 32), or a single
// not-found beat; the priority pick over the match flags selects each beat.
// Clear: one beat.
// in_stall_o is high while an item is in work. When the receiver stalls, the
// output register holds its beat and the block waits for it to drain.
// Reset empties the table; box contents need no clearing pass.
module grid_bounding_box_table #(
  parameter int unsigned MAX_GRIDS = gbbt_pkg::MAX_GRIDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [gbbt_pkg::ID_W-1:0]      grid_id_i,
  input  logic signed [gbbt_pkg::COORD_W-1:0] x_coord_i,
  input  logic signed [gbbt_pkg::COORD_W-1:0] y_coord_i,
  input  logic signed [gbbt_pkg::COORD_W-1:0] z_coord_i,
  input  logic [gbbt_pkg::RAD_W-1:0]     radius_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gbbt_pkg::ID_W-1:0]      match_id_o,
  output logic                           found_o,
  output logic                           status_o,
  output logic                           last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_GRIDS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_CLEAR,
    ST_QUERY
  } state_e;

  state_e                          state_q;
  logic [CNT_W-1:0]                count_q;
  logic [gbbt_pkg::RES_CNT_W-1:0]  res_cnt_q;
  logic                            out_valid_q;
  logic [gbbt_pkg::ID_W-1:0]       out_id_q;
  logic                            out_found_q;
  logic                            out_status_q;
  logic                            out_last_q;
  gbbt_pkg::point_t                vtx_q;
  logic [gbbt_pkg::ID_W-1:0]       new_id_q;

  logic                            accept;
  logic                            out_free;
  logic                            emit;
  logic                            hit;
  logic                            full;
  logic                            res_last;
  gbbt_pkg::cell_ctrl_t            ctrl;
  gbbt_pkg::point_t                pt_in;
  gbbt_pkg::entry_t                entry_w [MAX_GRIDS];
  logic [MAX_GRIDS-1:0]            lt_w, eq_w, match_w, valid_w, pick_w;
  logic [MAX_GRIDS-1:0]            first_w, rest_w;
  logic [gbbt_pkg::ID_W-1:0]       pick_key;

  // handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = out_free && (state_q != ST_IDLE);

  assign pt_in.x = x_coord_i;
  assign pt_in.y = y_coord_i;
  assign pt_in.z = z_coord_i;

  // broadcast commands
  assign hit  = |eq_w;
  assign full = (count_q == CNT_W'(MAX_GRIDS));
  always_comb begin
    ctrl.cmp_add = accept && (func_i == gbbt_pkg::FUNC_ADD);
    ctrl.cmp_qry = accept && (func_i == gbbt_pkg::FUNC_QUERY);
    ctrl.ins     = (state_q == ST_ADD) && out_free && !hit && !full;
    ctrl.upd     = (state_q == ST_ADD) && out_free && hit;
  end

  // chain of cells, cell 0 holds the lowest id
  for (genvar g = 0; g < MAX_GRIDS; g++) begin : g_cell
    logic             left_lt;
    gbbt_pkg::entry_t left_entry;

    assign valid_w[g] = (count_q > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = entry_w[0];
    end else begin : g_body
      assign left_lt    = lt_w[g-1];
      assign left_entry = entry_w[g-1];
    end

    gbbt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .valid_i      (valid_w[g]),
      .cmp_id_i     (grid_id_i),
      .pt_i         (pt_in),
      .radius_i     (radius_i),
      .new_id_i     (new_id_q),
      .vtx_i        (vtx_q),
      .left_entry_i (left_entry),
      .left_lt_i    (left_lt),
      .pick_i       (pick_w[g]),
      .entry_o      (entry_w[g]),
      .lt_o         (lt_w[g]),
      .eq_o         (eq_w[g]),
      .match_o      (match_w[g])
    );
  end

  // lowest pending match and its key
  assign first_w = match_w & (~match_w + MAX_GRIDS'(1));
  assign rest_w  = match_w & ~first_w;
  assign pick_w  = ((state_q == ST_QUERY) && out_free) ? first_w : '0;

  always_comb begin
    pick_key = '0;
    for (int i = 0; i < MAX_GRIDS; i++) begin
      pick_key = pick_key | (entry_w[i].key & {gbbt_pkg::ID_W{first_w[i]}});
    end
  end

  assign res_last = (rest_w == '0) ||
                    (res_cnt_q == gbbt_pkg::RES_CNT_W'(gbbt_pkg::MAX_RESULTS - 1));

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      res_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      out_id_q     <= '0;
      out_found_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (func_i)
              gbbt_pkg::FUNC_ADD: begin
                state_q <= ST_ADD;
              end
              gbbt_pkg::FUNC_QUERY: begin
                res_cnt_q <= '0;
                state_q   <= ST_QUERY;
              end
              gbbt_pkg::FUNC_CLEAR: begin
                count_q <= '0;
                state_q <= ST_CLEAR;
              end
              default: begin
                state_q <= ST_IDLE;
              end
            endcase
          end
        end
        ST_ADD: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_id_q     <= '0;
            out_found_q  <= 1'b0;
            out_status_q <= !hit && full;
            out_last_q   <= 1'b1;
            if (ctrl.ins) begin
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= ST_IDLE;
          end
        end
        ST_CLEAR: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_id_q     <= '0;
            out_found_q  <= 1'b0;
            out_status_q <= 1'b0;
            out_last_q   <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        ST_QUERY: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= 1'b0;
            if (match_w == '0) begin
              out_id_q    <= '0;
              out_found_q <= 1'b0;
              out_last_q  <= 1'b1;
              state_q     <= ST_IDLE;
            end else begin
              out_id_q    <= pick_key;
              out_found_q <= 1'b1;
              out_last_q  <= res_last;
              res_cnt_q   <= res_cnt_q + gbbt_pkg::RES_CNT_W'(1);
              if (res_last) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

  // vertex and id held for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      vtx_q    <= pt_in;
      new_id_q <= grid_id_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign match_id_o  = out_id_q;
  assign found_o     = out_found_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // table never holds more entries than cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_GRIDS))
    else $error("entry count above table size");

  // count grows by one entry at a time or drops to empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == '0)))
    else $error("entry count jumped");

  // keys are unique, so at most one cell matches an add
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> $onehot0(eq_w))
    else $error("duplicate key in table");

  // keys are sorted, so the smaller-than flags form a prefix of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> (((lt_w >> 1) & ~lt_w) == '0))
    else $error("table out of order");

endmodule
